// ----- rtl/swam_pkg.sv -----
`timescale 1ns / 1ps

package swam_pkg;

    // Default configuration, handed to the top level as parameter defaults.
    localparam int WINDOW_DEF       = 256;
    localparam int DELAY_DEF        = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Reported positions are the low bits of the window index.
    localparam int POS_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } state_t;

    // Control part of the running best candidate passed from cell to cell.
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } cand_ctl_t;

endpackage

// ----- rtl/swam_cell.sv -----
`timescale 1ns / 1ps

module swam_cell #(
    parameter int SAMPLE_WIDTH = swam_pkg::SAMPLE_WIDTH_DEF,
    parameter int POS          = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      shift_en,
    input  logic [SAMPLE_WIDTH-1:0]   sample_in,
    output logic [SAMPLE_WIDTH-1:0]   sample_out,
    input  swam_pkg::cand_ctl_t       cand_in,
    input  logic [SAMPLE_WIDTH-1:0]   cand_val_in,
    output swam_pkg::cand_ctl_t       cand_out,
    output logic [SAMPLE_WIDTH-1:0]   cand_val_out
);

    logic [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    swam_pkg::cand_ctl_t     ctl_reg, ctl_next;
    logic [SAMPLE_WIDTH-1:0] val_reg, val_next;

    always_comb begin
        sample_next = shift_en ? sample_in : sample_reg;
        ctl_next    = cand_in;
        val_next    = cand_val_in;
        // Strictly greater takes over, so ties keep the lower position.
        if ($signed(sample_reg) > $signed(cand_val_in)) begin
            ctl_next.pos = swam_pkg::POS_W'(POS);
            val_next     = sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            ctl_reg    <= '0;
        end else begin
            sample_reg <= sample_next;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign sample_out   = sample_reg;
    assign cand_out     = ctl_reg;
    assign cand_val_out = val_reg;

endmodule

// ----- rtl/swam_delay.sv -----
`timescale 1ns / 1ps

module swam_delay #(
    parameter int DELAY = swam_pkg::DELAY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [swam_pkg::POS_W-1:0] pos_in,
    output logic [swam_pkg::POS_W-1:0] pos_out
);

    logic [swam_pkg::POS_W-1:0] dly_reg  [DELAY];
    logic [swam_pkg::POS_W-1:0] dly_next [DELAY];

    always_comb begin
        dly_next[0] = push ? pos_in : dly_reg[0];
        for (int i = 1; i < DELAY; i++) begin
            dly_next[i] = push ? dly_reg[i-1] : dly_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DELAY; i++) begin
                dly_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < DELAY; i++) begin
                dly_reg[i] <= dly_next[i];
            end
        end
    end

    // Tap that the oldest stage takes on a push.
    assign pos_out = dly_next[DELAY-1];

endmodule

// ----- rtl/sliding_window_argmax_unit.sv -----
// Requests: a new request is taken only in idle, after the last has been pushed.
// Flow: the scan walks the running maximum along the chain of WINDOW cells,
//   one cell per cycle, then the result is captured, pushed and the block
//   returns to idle; an unread result stalls the push.
// Reset (aresetn low, synchronous): window samples and delay line go to zero,
//   no result is pending, and the block is ready for a request.
`timescale 1ns / 1ps

module sliding_window_argmax_unit #(
    parameter int WINDOW       = swam_pkg::WINDOW_DEF,
    parameter int DELAY        = swam_pkg::DELAY_DEF,
    parameter int SAMPLE_WIDTH = swam_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_WIDTH-1:0]    s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [swam_pkg::POS_W-1:0] m_peak_position
);

    // Most negative sample: seeds the scan at position 0, which cell 0 keeps or takes over.
    localparam logic [SAMPLE_WIDTH-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    swam_pkg::state_t state_reg, state_next;

    logic                       start_reg, start_next;
    logic                       m_valid_reg, m_valid_next;
    logic [swam_pkg::POS_W-1:0] peak_hold_reg, peak_hold_next;
    logic [swam_pkg::POS_W-1:0] m_pos_reg, m_pos_next;

    logic                       accept;
    logic                       push;
    logic                       done;
    logic [swam_pkg::POS_W-1:0] tap_pos;

    // Chain wiring: index i is the output of cell i.
    logic [SAMPLE_WIDTH-1:0] sample_w [WINDOW];
    swam_pkg::cand_ctl_t     ctl_w    [WINDOW];
    logic [SAMPLE_WIDTH-1:0] val_w    [WINDOW];

    swam_pkg::cand_ctl_t seed_ctl;

    assign seed_ctl.valid = start_reg;
    assign seed_ctl.pos   = '0;

    // The window is a shift line of cells; position 0 holds the newest sample.
    // A scan token carries the best value and position from cell 0 upward.
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            swam_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .POS          (i)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .shift_en     (accept),
                .sample_in    (s_sample),
                .sample_out   (sample_w[i]),
                .cand_in      (seed_ctl),
                .cand_val_in  (MIN_SAMPLE),
                .cand_out     (ctl_w[i]),
                .cand_val_out (val_w[i])
            );
        end else begin : g_body
            swam_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .POS          (i)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .shift_en     (accept),
                .sample_in    (sample_w[i-1]),
                .sample_out   (sample_w[i]),
                .cand_in      (ctl_w[i-1]),
                .cand_val_in  (val_w[i-1]),
                .cand_out     (ctl_w[i]),
                .cand_val_out (val_w[i])
            );
        end
    end

    // The token leaving the last cell carries the finished position.
    assign done = ctl_w[WINDOW-1].valid;

    swam_delay #(
        .DELAY (DELAY)
    ) u_delay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pos_in  (peak_hold_reg),
        .pos_out (tap_pos)
    );

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        start_next     = 1'b0;
        peak_hold_next = peak_hold_reg;
        m_pos_next     = m_pos_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        push           = 1'b0;
        unique case (state_reg)
            swam_pkg::ST_IDLE: begin
                // Take a request; the window shifts on this edge, then start the scan.
                s_ready = 1'b1;
                if (s_valid) begin
                    start_next = 1'b1;
                    state_next = swam_pkg::ST_SCAN;
                end
            end
            swam_pkg::ST_SCAN: begin
                // Hold the window still until the token leaves the last cell.
                if (done) begin
                    peak_hold_next = ctl_w[WINDOW-1].pos;
                    state_next     = swam_pkg::ST_PUSH;
                end
            end
            swam_pkg::ST_PUSH: begin
                // Advance the delay line only once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    push         = 1'b1;
                    m_pos_next   = tap_pos;
                    m_valid_next = 1'b1;
                    state_next   = swam_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swam_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swam_pkg::ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        peak_hold_reg <= peak_hold_next;
        m_pos_reg     <= m_pos_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_peak_position = m_pos_reg;

    // An accepted request launches the scan token on the next cycle.
    a_start_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> start_reg)
        else $error("scan token not launched after request");

    // The token is a single pulse.
    a_start_single: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |=> !start_reg)
        else $error("scan token longer than one cycle");

    // A finished scan only arrives while the controller waits for it.
    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == swam_pkg::ST_SCAN))
        else $error("scan finished outside of scan state");

    // No new request while the scan token is being launched or sits in cell 0.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_w[0].valid || start_reg) |-> !s_ready)
        else $error("request taken during scan");

    // A pending result is never overwritten by the next push.
    a_push_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swam_pkg::ST_PUSH && m_valid_reg && !m_ready)
            |=> (state_reg == swam_pkg::ST_PUSH))
        else $error("push while result pending");

endmodule

// ----- tb/tb_sliding_window_argmax_unit.sv -----
`timescale 1ns / 1ps

// Sample-by-sample check of the sliding window argmax unit.
// Every accepted request runs through a local copy of the window and of the
// position delay line; that copy's position, or a typed row's own one, is
// queued and compared with the next result the block hands out. A short table
// of hand-picked samples comes first, then random segments shaped to walk the
// peak across the whole window: noise, falling and rising ramps, runs of ties.
module tb_sliding_window_argmax_unit;
    import swam_pkg::*;

    localparam int WINDOW         = WINDOW_DEF;
    localparam int DELAY          = DELAY_DEF;
    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int RANDOM_SAMPLES = 1150;
    // The limit covers requests with a sender gap and a receiver stall
    // stacked on top of them.
    localparam int IDLE_LIMIT     = 8 * (WINDOW + 3) + 4000;
    localparam int SETTLE_CYCLES  = WINDOW + 3 + 16;

    // Shapes of the random segments.
    typedef enum int {
        SEG_NOISE,
        SEG_NEGATIVE,
        SEG_FALL,
        SEG_LONG_FALL,
        SEG_RISE,
        SEG_TIES,
        SEG_FLAT
    } segment_t;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        logic [SW-1:0]    sample;
        logic             typed;
        logic [POS_W-1:0] pos;
    } sample_row_t;

    localparam int N_DIRECTED = 21;
    localparam sample_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Early outputs: the delay line still shows its reset zeros.
        '{16'h8000, 1'b1, 8'd0},   // most negative sample
        '{16'h7FFF, 1'b1, 8'd0},   // most positive sample
        '{16'h7FFF, 1'b1, 8'd0},   // tie at the top
        '{16'hFFFF, 1'b1, 8'd0},
        '{16'h0000, 1'b1, 8'd0},
        '{16'h5555, 1'b1, 8'd0},
        '{16'hAAAA, 1'b1, 8'd0},
        // Peak found after the first sample: the zero-filled window beats it,
        // and the newest zero (position 1) wins the tie.
        '{16'h0001, 1'b1, 8'd1},
        // After the second and third samples the newest maximum sits at 0.
        '{16'h8001, 1'b1, 8'd0},
        '{16'h7FFE, 1'b1, 8'd0},
        // From here on the local copy decides.
        '{16'h0100, 1'b0, 8'd0},   // +1.0
        '{16'hFF00, 1'b0, 8'd0},   // -1.0
        '{16'h7FFF, 1'b0, 8'd0},
        '{16'h7FFF, 1'b0, 8'd0},
        '{16'h8000, 1'b0, 8'd0},
        '{16'h8000, 1'b0, 8'd0},
        '{16'h0000, 1'b0, 8'd0},
        '{16'h0000, 1'b0, 8'd0},
        '{16'h00FF, 1'b0, 8'd0},
        '{16'h3FFF, 1'b0, 8'd0},
        '{16'hC000, 1'b0, 8'd0}
    };

    localparam logic [SW-1:0] TIE_VALUES [7] = '{
        16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [SW-1:0]        s_sample  = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [POS_W-1:0]     m_peak_position;

    // Expectation typed into the table, travelling alongside the request.
    logic                 row_typed = 1'b0;
    logic [POS_W-1:0]     row_pos   = '0;

    // Local copy of the window (index 0 = newest) and of the delay line.
    logic signed [SW-1:0] peak_window [WINDOW];
    logic [POS_W-1:0]     peak_delay [DELAY];

    logic [POS_W-1:0]     expected_peaks [$];
    logic signed [SW-1:0] ramp_level = '0;
    int                   mismatches  = 0;
    int                   idle_cycles = 0;
    int                   stall_left  = 0;
    bit                   calm        = 1'b0;

    sliding_window_argmax_unit #(
        .WINDOW      (WINDOW),
        .DELAY       (DELAY),
        .SAMPLE_WIDTH(SW)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_position(m_peak_position)
    );

    always #1 aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t  MISMATCH  %s", $time, what);
    endtask

    // Shift the sample in, find the greatest entry (ties go to the newest),
    // push its low position bits into the delay line and return the oldest.
    function automatic logic [POS_W-1:0] track_peak(input logic [SW-1:0] sample);
        int best;
        for (int i = WINDOW - 1; i > 0; i--) peak_window[i] = peak_window[i - 1];
        peak_window[0] = $signed(sample);
        best = 0;
        for (int i = 1; i < WINDOW; i++) begin
            if (peak_window[i] > peak_window[best]) best = i;
        end
        for (int i = DELAY - 1; i > 0; i--) peak_delay[i] = peak_delay[i - 1];
        peak_delay[0] = POS_W'(best);
        return peak_delay[DELAY - 1];
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(40, 400);
    endfunction

    function automatic logic [SW-1:0] shape_sample(input segment_t shape);
        logic [SW-1:0] v;
        case (shape)
            SEG_NOISE:    v = SW'($urandom);
            SEG_NEGATIVE: v = {1'b1, (SW - 1)'($urandom)};
            SEG_FALL, SEG_LONG_FALL: begin
                ramp_level = ramp_level - SW'($urandom_range(1, 100));
                v = ramp_level;
            end
            SEG_RISE: begin
                ramp_level = ramp_level + SW'($urandom_range(1, 100));
                v = ramp_level;
            end
            SEG_TIES:     v = TIE_VALUES[$urandom_range(0, 6)];
            default:      v = ramp_level;
        endcase
        return v;
    endfunction

    // Present one request at the falling edge and hold it until it is taken.
    task automatic send_sample(input logic [SW-1:0] v, input logic typed,
                               input logic [POS_W-1:0] pos);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_sample  <= v;
        row_typed <= typed;
        row_pos   <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and hold off until every queued position has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (expected_peaks.size() == 0);
    endtask

    // Receiver: accept most cycles, stall in short bursts and now and then
    // for a long stretch; during calm segments never stall.
    always @(negedge aclk) begin
        int roll;
        if (calm) begin
            m_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall_left = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(30, 400);
            end
        end
    end

    // Scoreboard: queue a prediction for every accepted request, compare
    // every accepted result with the oldest one, and count idle cycles.
    always @(posedge aclk) begin
        logic [POS_W-1:0] want;
        logic             moved;
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            moved = 1'b0;
            if (s_valid && s_ready) begin
                moved = 1'b1;
                want = track_peak(s_sample);
                if (row_typed) want = row_pos;
                expected_peaks.push_back(want);
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_peaks.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, peak_position=%0d",
                                            m_peak_position));
                end else begin
                    want = expected_peaks.pop_front();
                    if (m_peak_position !== want)
                        flag_mismatch($sformatf("peak_position got %0d, want %0d",
                                                m_peak_position, want));
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no request or result for %0d cycles", IDLE_LIMIT);
        $display("** sliding_window_argmax_unit: FAILED **");
        $finish;
    end

    initial begin
        int       sent;
        int       seg_len;
        int       pick;
        segment_t shape;

        for (int i = 0; i < WINDOW; i++) peak_window[i] = '0;
        for (int i = 0; i < DELAY; i++) peak_delay[i] = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, then let the pipeline run dry once.
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].typed,
                        DIRECTED_ROWS[r].pos);
        end
        drain_results();

        // Random segments. Long falls start at the top of the range and run for
        // at least the window length, so the peak walks out to the oldest slot.
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      shape = SEG_NOISE;
            else if (pick < 45) shape = SEG_NEGATIVE;
            else if (pick < 55) shape = SEG_FALL;
            else if (pick < 63) shape = SEG_LONG_FALL;
            else if (pick < 73) shape = SEG_RISE;
            else if (pick < 93) shape = SEG_TIES;
            else                shape = SEG_FLAT;

            if (shape == SEG_LONG_FALL) begin
                seg_len    = $urandom_range(WINDOW, WINDOW + 40);
                ramp_level = 16'sh7FFF;
            end else begin
                seg_len    = $urandom_range(10, 60);
                ramp_level = SW'($urandom);
            end
            calm = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < seg_len; k++) begin
                send_sample(shape_sample(shape), 1'b0, '0);
                sent++;
            end
            calm = 1'b0;
            if ($urandom_range(0, 5) == 0) drain_results();
        end

        // Wait for the last result, then watch for stray ones.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_peaks.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_peaks.size()));

        if (mismatches == 0) begin
            $display("** sliding_window_argmax_unit: PASSED **");
        end else begin
            $display("** sliding_window_argmax_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sliding_window_argmax_unit.f -----
rtl/swam_pkg.sv
rtl/swam_cell.sv
rtl/swam_delay.sv
rtl/sliding_window_argmax_unit.sv
tb/tb_sliding_window_argmax_unit.sv
